// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL; they compile away when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on the rising edge and disabled in reset
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising edge and disabled in reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/blr_pkg.sv =====
`timescale 1ns / 1ps

package blr_pkg;

  // Command codes carried in the input tuser bit
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // How the cursor walks the current line
  typedef enum logic [2:0] {
    MODE_HORIZ         = 3'd0,
    MODE_VERT          = 3'd1,
    MODE_SHALLOW_UP    = 3'd2,
    MODE_SHALLOW_DOWN  = 3'd3,
    MODE_STEEP_RIGHT   = 3'd4,
    MODE_STEEP_LEFT    = 3'd5
  } walk_mode_t;

  // Flags of one result transaction
  typedef struct packed {
    logic valid;
    logic last;
  } pix_flags_t;

endpackage

// ===== hdl/blr_in_reg.sv =====
`timescale 1ns / 1ps

module blr_in_reg #(
  parameter int COORD_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_cmd,
  input  logic [4*COORD_BITS-1:0] in_data,   // start_x, start_y, end_x, end_y
  input  logic                    take,
  output logic                    item_valid,
  output logic                    item_cmd,
  output logic [COORD_BITS-1:0]   item_sx,
  output logic [COORD_BITS-1:0]   item_sy,
  output logic [COORD_BITS-1:0]   item_ex,
  output logic [COORD_BITS-1:0]   item_ey
);

  // Accept when empty or when the held item moves on this cycle
  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // Capture the payload of each accepted transaction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_cmd <= in_cmd;
      item_sx  <= in_data[0*COORD_BITS +: COORD_BITS];
      item_sy  <= in_data[1*COORD_BITS +: COORD_BITS];
      item_ex  <= in_data[2*COORD_BITS +: COORD_BITS];
      item_ey  <= in_data[3*COORD_BITS +: COORD_BITS];
    end
  end

endmodule

// ===== hdl/blr_walker.sv =====
`timescale 1ns / 1ps

module blr_walker #(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic                  item_cmd,
  input  logic [COORD_BITS-1:0] item_sx,
  input  logic [COORD_BITS-1:0] item_sy,
  input  logic [COORD_BITS-1:0] item_ex,
  input  logic [COORD_BITS-1:0] item_ey,
  output logic [COORD_BITS-1:0] res_x,
  output logic [COORD_BITS-1:0] res_y,
  output blr_pkg::pix_flags_t   res_flags,
  output logic                  line_busy
);

  import blr_pkg::*;

  localparam int ERR_BITS = COORD_BITS + 3;

  // Line state
  logic [COORD_BITS-1:0]       cursor_x, cursor_x_next;
  logic [COORD_BITS-1:0]       cursor_y, cursor_y_next;
  logic [COORD_BITS-1:0]       stop_coord, stop_coord_next;
  logic signed [ERR_BITS-1:0]  error_term, error_term_next;
  logic [COORD_BITS-1:0]       delta_major, delta_major_next;
  logic [COORD_BITS-1:0]       delta_minor, delta_minor_next;
  walk_mode_t                  walk_mode, walk_mode_next;
  logic                        line_busy_next;

  // Endpoint geometry of the item being loaded
  logic [COORD_BITS-1:0]       dx, dy;
  logic [COORD_BITS-1:0]       ex_m1, y_lo, y_hi_m1;
  logic                        last;

  // Error term updates for one step
  logic signed [ERR_BITS-1:0]  err_keep, err_move;

  assign dx      = (item_sx > item_ex) ? item_sx - item_ex : item_ex - item_sx;
  assign dy      = (item_sy > item_ey) ? item_sy - item_ey : item_ey - item_sy;
  assign ex_m1   = item_ex - COORD_BITS'(1);
  assign y_lo    = (item_sy < item_ey) ? item_sy : item_ey;
  assign y_hi_m1 = ((item_sy < item_ey) ? item_ey : item_sy) - COORD_BITS'(1);

  assign err_keep = error_term + ERR_BITS'({delta_minor, 1'b0});
  assign err_move = error_term + ERR_BITS'({delta_minor, 1'b0})
                    - ERR_BITS'({delta_major, 1'b0});

  // Load a new line or take one step along the current one
  always_comb begin
    cursor_x_next    = cursor_x;
    cursor_y_next    = cursor_y;
    stop_coord_next  = stop_coord;
    error_term_next  = error_term;
    delta_major_next = delta_major;
    delta_minor_next = delta_minor;
    walk_mode_next   = walk_mode;
    line_busy_next   = line_busy;
    last             = 1'b1;
    res_x            = '0;
    res_y            = '0;
    res_flags.valid  = 1'b0;
    res_flags.last   = 1'b1;

    if (item_cmd == CMD_LOAD) begin
      if (item_sy == item_ey) begin
        if (item_sx >= item_ex) begin
          // Empty line: drop it and report no pixel
          line_busy_next = 1'b0;
        end else begin
          walk_mode_next   = MODE_HORIZ;
          cursor_x_next    = item_sx;
          cursor_y_next    = item_sy;
          stop_coord_next  = ex_m1;
          delta_major_next = dx;
          delta_minor_next = '0;
          error_term_next  = '0;
          last             = (item_sx == ex_m1);
        end
      end else if (item_sx == item_ex) begin
        walk_mode_next   = MODE_VERT;
        cursor_x_next    = item_sx;
        cursor_y_next    = y_lo;
        stop_coord_next  = y_hi_m1;
        delta_major_next = dy;
        delta_minor_next = '0;
        error_term_next  = '0;
        last             = (y_lo == y_hi_m1);
      end else if (dy <= dx) begin
        // Shallow: start at the lower-x end
        if (item_sx > item_ex) begin
          cursor_x_next   = item_ex;
          cursor_y_next   = item_ey;
          stop_coord_next = item_sx;
          walk_mode_next  = (item_sy > item_ey) ? MODE_SHALLOW_UP : MODE_SHALLOW_DOWN;
        end else begin
          cursor_x_next   = item_sx;
          cursor_y_next   = item_sy;
          stop_coord_next = item_ex;
          walk_mode_next  = (item_ey > item_sy) ? MODE_SHALLOW_UP : MODE_SHALLOW_DOWN;
        end
        delta_major_next = dx;
        delta_minor_next = dy;
        error_term_next  = ERR_BITS'({dy, 1'b0}) - ERR_BITS'(dx);
        last             = 1'b0;
      end else begin
        // Steep: start at the lower-y end
        if (item_sy > item_ey) begin
          cursor_x_next   = item_ex;
          cursor_y_next   = item_ey;
          stop_coord_next = item_sy;
          walk_mode_next  = (item_sx > item_ex) ? MODE_STEEP_RIGHT : MODE_STEEP_LEFT;
        end else begin
          cursor_x_next   = item_sx;
          cursor_y_next   = item_sy;
          stop_coord_next = item_ey;
          walk_mode_next  = (item_ex > item_sx) ? MODE_STEEP_RIGHT : MODE_STEEP_LEFT;
        end
        delta_major_next = dy;
        delta_minor_next = dx;
        error_term_next  = ERR_BITS'({dx, 1'b0}) - ERR_BITS'(dy);
        last             = 1'b0;
      end

      if (!((item_sy == item_ey) && (item_sx >= item_ex))) begin
        line_busy_next  = !last;
        res_x           = cursor_x_next;
        res_y           = cursor_y_next;
        res_flags.valid = 1'b1;
        res_flags.last  = last;
      end
    end else if (line_busy) begin
      unique case (walk_mode)
        MODE_HORIZ: begin
          cursor_x_next = cursor_x + COORD_BITS'(1);
          last          = (cursor_x_next == stop_coord);
        end
        MODE_VERT: begin
          cursor_y_next = cursor_y + COORD_BITS'(1);
          last          = (cursor_y_next == stop_coord);
        end
        MODE_SHALLOW_UP, MODE_SHALLOW_DOWN: begin
          cursor_x_next = cursor_x + COORD_BITS'(1);
          if (error_term[ERR_BITS-1]) begin
            error_term_next = err_keep;
          end else begin
            cursor_y_next   = (walk_mode == MODE_SHALLOW_UP) ?
                              cursor_y + COORD_BITS'(1) : cursor_y - COORD_BITS'(1);
            error_term_next = err_move;
          end
          last = (cursor_x_next == stop_coord);
        end
        default: begin
          cursor_y_next = cursor_y + COORD_BITS'(1);
          if (error_term[ERR_BITS-1]) begin
            error_term_next = err_keep;
          end else begin
            cursor_x_next   = (walk_mode == MODE_STEEP_RIGHT) ?
                              cursor_x + COORD_BITS'(1) : cursor_x - COORD_BITS'(1);
            error_term_next = err_move;
          end
          last = (cursor_y_next == stop_coord);
        end
      endcase
      line_busy_next  = !last;
      res_x           = cursor_x_next;
      res_y           = cursor_y_next;
      res_flags.valid = 1'b1;
      res_flags.last  = last;
    end
  end

  // Commit the new line state as the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x    <= '0;
      cursor_y    <= '0;
      stop_coord  <= '0;
      error_term  <= '0;
      delta_major <= '0;
      delta_minor <= '0;
      walk_mode   <= MODE_HORIZ;
      line_busy   <= 1'b0;
    end else if (take) begin
      cursor_x    <= cursor_x_next;
      cursor_y    <= cursor_y_next;
      stop_coord  <= stop_coord_next;
      error_term  <= error_term_next;
      delta_major <= delta_major_next;
      delta_minor <= delta_minor_next;
      walk_mode   <= walk_mode_next;
      line_busy   <= line_busy_next;
    end
  end

endmodule

// ===== hdl/blr_out_reg.sv =====
`timescale 1ns / 1ps

module blr_out_reg #(
  parameter int COORD_BITS = 10,
  parameter int OUT_DATA_W = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [COORD_BITS-1:0] res_x,
  input  logic [COORD_BITS-1:0] res_y,
  input  blr_pkg::pix_flags_t   res_flags,
  output logic                  out_ready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // pixel_x, pixel_y, zero fill
  output logic                  m_tuser,   // pixel_valid
  output logic                  m_tlast    // last_pixel
);

  import blr_pkg::*;

  logic [COORD_BITS-1:0] pix_x;
  logic [COORD_BITS-1:0] pix_y;
  pix_flags_t            pix_flags;

  // Free when empty or when the held result leaves this cycle
  assign out_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= take;
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (take) begin
      pix_x     <= res_x;
      pix_y     <= res_y;
      pix_flags <= res_flags;
    end
  end

  assign m_tdata = OUT_DATA_W'({pix_y, pix_x});
  assign m_tuser = pix_flags.valid;
  assign m_tlast = pix_flags.last;

endmodule

// ===== hdl/bresenham_line_rasterizer.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Transaction          Payload
// s_*       in   one command          tuser: cmd; tdata: start_x, start_y, end_x, end_y
// m_*       out  one result per cmd   tdata: pixel_x, pixel_y; tuser: pixel_valid;
//                                     tlast: last_pixel
//
// Throughput: one command per clock while m_tready is high; a command passes through the
// input register and then the result register to m_tvalid. Each step is one add and
// compare on the error term, between the input register and the result register; line
// state updates as a command moves on. rst clears both valid flags and the line state;
// no line is loaded after reset. While m_tready is low the result holds, one more command
// is taken into the input register if it is empty, then s_tready drops.

module bresenham_line_rasterizer #(
  parameter int COORD_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]    s_tdata,   // start_x, start_y, end_x, end_y
  input  logic                                 s_tuser,   // cmd
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((2*COORD_BITS+7)/8)*8-1:0]    m_tdata,   // pixel_x, pixel_y
  output logic                                 m_tuser,   // pixel_valid
  output logic                                 m_tlast    // last_pixel
);

  import blr_pkg::*;

  `include "assert_macros.svh"

  localparam int OUT_DATA_W = ((2*COORD_BITS+7)/8)*8;

  logic                  item_valid;
  logic                  item_cmd;
  logic [COORD_BITS-1:0] item_sx, item_sy, item_ex, item_ey;
  logic [COORD_BITS-1:0] res_x, res_y;
  pix_flags_t            res_flags;
  logic                  line_busy;
  logic                  out_ready;
  logic                  take;

  // Move the held command through the walker when the result register frees
  assign take = item_valid && out_ready;

  blr_in_reg #(
    .COORD_BITS (COORD_BITS)
  ) u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_cmd     (s_tuser),
    .in_data    (s_tdata[4*COORD_BITS-1:0]),
    .take       (take),
    .item_valid (item_valid),
    .item_cmd   (item_cmd),
    .item_sx    (item_sx),
    .item_sy    (item_sy),
    .item_ex    (item_ex),
    .item_ey    (item_ey)
  );

  blr_walker #(
    .COORD_BITS (COORD_BITS)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item_cmd  (item_cmd),
    .item_sx   (item_sx),
    .item_sy   (item_sy),
    .item_ex   (item_ex),
    .item_ey   (item_ey),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_flags (res_flags),
    .line_busy (line_busy)
  );

  blr_out_reg #(
    .COORD_BITS (COORD_BITS),
    .OUT_DATA_W (OUT_DATA_W)
  ) u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_flags (res_flags),
    .out_ready (out_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // Checks
  `ASSERT_IMPLIES(a_no_pixel_zero, clk, rst, m_tvalid && !m_tuser, (m_tdata == '0) && m_tlast, "result without pixel must be zero and last")
  `ASSERT_NEXT(a_last_ends_line, clk, rst, take && res_flags.last, !line_busy, "line still busy after its last pixel")
  `ASSERT_IMPLIES(a_idle_advance, clk, rst, take && (item_cmd == CMD_ADVANCE) && !line_busy, !res_flags.valid && res_flags.last, "advance with no line gave a pixel")
  `ASSERT_NEXT(a_take_shows, clk, rst, take, m_tvalid, "walked command produced no result")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import blr_pkg::*;

  localparam int CB          = 10;
  localparam int HOLD_CYCLES = 400;
  localparam int STUCK_LIMIT = 5000;
  localparam int MAX_REPORTS = 20;

  // One command as the sender offers it
  typedef struct {
    logic          cmd;
    logic [CB-1:0] sx;
    logic [CB-1:0] sy;
    logic [CB-1:0] ex;
    logic [CB-1:0] ey;
    bit            drain;
  } line_cmd_t;

  // One pixel result
  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic          valid;
    logic          last;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // start_x, start_y, end_x, end_y
  logic        s_tuser = CMD_LOAD;   // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // pixel_x, pixel_y, 4 zero bits
  logic        m_tuser;        // pixel_valid
  logic        m_tlast;        // last_pixel

  line_cmd_t pending_cmds[$];
  pixel_t    expected_pixels[$];
  line_cmd_t cur_cmd;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_taken     = 0;
  int hold_left      = 0;
  int stuck_cycles   = 0;
  int mismatches     = 0;

  // Line walker state, mirrors the block
  logic [CB-1:0] line_x;
  logic [CB-1:0] line_y;
  logic [CB-1:0] line_stop;
  int            line_err;
  int            line_dmaj;
  int            line_dmin;
  walk_mode_t    line_mode;
  logic          line_active;

  bresenham_line_rasterizer #(.COORD_BITS(CB)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Compute the pixel that one accepted command yields and queue it
  task automatic predict_pixel(input line_cmd_t c);
    int     sxi, syi, exi, eyi, dx, dy;
    logic   last;
    logic [CB-1:0] ox, oy;
    pixel_t px;
    sxi = c.sx;
    syi = c.sy;
    exi = c.ex;
    eyi = c.ey;
    dx = (sxi > exi) ? sxi - exi : exi - sxi;
    dy = (syi > eyi) ? syi - eyi : eyi - syi;
    px = '{x: '0, y: '0, valid: 1'b0, last: 1'b1};
    if (c.cmd == CMD_LOAD) begin
      if (dy == 0 && sxi >= exi) begin
        // empty line: nothing to walk
        line_active = 1'b0;
      end else begin
        if (dy == 0) begin
          line_mode = MODE_HORIZ;
          line_x    = c.sx;
          line_y    = c.sy;
          line_stop = c.ex - 1'b1;
          line_dmaj = dx;
          line_dmin = 0;
          line_err  = 0;
          last      = (line_x == line_stop);
        end else if (dx == 0) begin
          line_mode = MODE_VERT;
          line_x    = c.sx;
          line_y    = (syi < eyi) ? c.sy : c.ey;
          line_stop = ((syi < eyi) ? c.ey : c.sy) - 1'b1;
          line_dmaj = dy;
          line_dmin = 0;
          line_err  = 0;
          last      = (line_y == line_stop);
        end else if (dy <= dx) begin
          // shallow: start at the lower-x end
          if (sxi > exi) begin
            line_x = c.ex; line_y = c.ey; ox = c.sx; oy = c.sy;
          end else begin
            line_x = c.sx; line_y = c.sy; ox = c.ex; oy = c.ey;
          end
          line_mode = (oy > line_y) ? MODE_SHALLOW_UP : MODE_SHALLOW_DOWN;
          line_stop = ox;
          line_dmaj = dx;
          line_dmin = dy;
          line_err  = 2 * dy - dx;
          last      = 1'b0;
        end else begin
          // steep: start at the lower-y end
          if (syi > eyi) begin
            line_x = c.ex; line_y = c.ey; ox = c.sx; oy = c.sy;
          end else begin
            line_x = c.sx; line_y = c.sy; ox = c.ex; oy = c.ey;
          end
          line_mode = (ox > line_x) ? MODE_STEEP_RIGHT : MODE_STEEP_LEFT;
          line_stop = oy;
          line_dmaj = dy;
          line_dmin = dx;
          line_err  = 2 * dx - dy;
          last      = 1'b0;
        end
        line_active = !last;
        px = '{x: line_x, y: line_y, valid: 1'b1, last: last};
      end
    end else if (line_active) begin
      case (line_mode)
        MODE_HORIZ: begin
          line_x = line_x + 1'b1;
          last   = (line_x == line_stop);
        end
        MODE_VERT: begin
          line_y = line_y + 1'b1;
          last   = (line_y == line_stop);
        end
        MODE_SHALLOW_UP, MODE_SHALLOW_DOWN: begin
          line_x = line_x + 1'b1;
          if (line_err < 0) begin
            line_err = line_err + 2 * line_dmin;
          end else begin
            line_y   = (line_mode == MODE_SHALLOW_UP) ? line_y + 1'b1 : line_y - 1'b1;
            line_err = line_err + 2 * (line_dmin - line_dmaj);
          end
          last = (line_x == line_stop);
        end
        default: begin
          line_y = line_y + 1'b1;
          if (line_err < 0) begin
            line_err = line_err + 2 * line_dmin;
          end else begin
            line_x   = (line_mode == MODE_STEEP_RIGHT) ? line_x + 1'b1 : line_x - 1'b1;
            line_err = line_err + 2 * (line_dmin - line_dmaj);
          end
          last = (line_y == line_stop);
        end
      endcase
      line_active = !last;
      px = '{x: line_x, y: line_y, valid: 1'b1, last: last};
    end
    expected_pixels = {expected_pixels, px};
  endtask

  // Offer commands; predict each one as it is accepted
  always @(posedge clk) begin
    logic nxt_valid;
    nxt_valid = s_tvalid;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_pixel(cur_cmd);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_cmds.size() > 0 &&
          $urandom_range(99) >= send_idle_pct &&
          !(pending_cmds[0].drain && expected_pixels.size() != 0)) begin
        cur_cmd = pending_cmds.pop_front();
        s_tdata <= {cur_cmd.ey, cur_cmd.ex, cur_cmd.sy, cur_cmd.sx};
        s_tuser <= cur_cmd.cmd;
        nxt_valid = 1'b1;
      end
    end
    s_tvalid <= nxt_valid;
  end

  // Drive ready: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_req != hold_taken) begin
      hold_taken <= hold_taken + 1;
      hold_left  <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    pixel_t want;
    pixel_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = '{x: m_tdata[CB-1:0], y: m_tdata[2*CB-1:CB], valid: m_tuser, last: m_tlast};
      if (expected_pixels.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected pixel x=%0d y=%0d valid=%0b last=%0b",
                   $time, got.x, got.y, got.valid, got.last);
      end else begin
        want = expected_pixels.pop_front();
        if (got.x !== want.x || got.y !== want.y ||
            got.valid !== want.valid || got.last !== want.last) begin
          mismatches = mismatches + 1;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: expected x=%0d y=%0d v=%0b l=%0b, got x=%0d y=%0d v=%0b l=%0b",
                     $time, want.x, want.y, want.valid, want.last,
                     got.x, got.y, got.valid, got.last);
        end
      end
    end
  end

  // Stop a hung run: count cycles with work outstanding and no transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else if (s_tvalid || pending_cmds.size() > 0 || expected_pixels.size() > 0) begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic add_cmd(input logic cmd, input int sx, input int sy, input int ex,
                         input int ey, input bit drain = 1'b0);
    line_cmd_t c;
    c.cmd   = cmd;
    c.sx    = CB'(sx);
    c.sy    = CB'(sy);
    c.ex    = CB'(ex);
    c.ey    = CB'(ey);
    c.drain = drain;
    pending_cmds = {pending_cmds, c};
  endtask

  // Queue about n commands: mostly a short line then its advances
  task automatic add_random(input int n, input bit drain_first);
    int added, sx, sy, ex, ey, dx, dy, span, steps;
    bit drain;
    added = 0;
    drain = drain_first;
    while (added < n) begin
      if ($urandom_range(99) < 8) begin
        // noise: any command, any coordinates
        add_cmd(1'($urandom_range(1)), $urandom_range(1023), $urandom_range(1023),
                $urandom_range(1023), $urandom_range(1023), drain);
        added = added + 1;
      end else begin
        sx = $urandom_range(1023);
        sy = $urandom_range(1023);
        if ($urandom_range(99) < 10) begin
          // long line, usually cut short by the next load
          ex    = $urandom_range(1023);
          ey    = $urandom_range(1023);
          steps = $urandom_range(30);
        end else begin
          span = ($urandom_range(3) == 0) ? 0 : $urandom_range(16);
          dx = $urandom_range(2 * span) - span;
          dy = ($urandom_range(4) == 0) ? 0 : $urandom_range(2 * span) - span;
          ex = sx + dx;
          ey = sy + dy;
          if (ex < 0) ex = 0;
          if (ex > 1023) ex = 1023;
          if (ey < 0) ey = 0;
          if (ey > 1023) ey = 1023;
          dx = (ex > sx) ? ex - sx : sx - ex;
          dy = (ey > sy) ? ey - sy : sy - ey;
          steps = ((dx > dy) ? dx : dy) + $urandom_range(2) - 1;
          if (steps < 0) steps = 0;
        end
        add_cmd(CMD_LOAD, sx, sy, ex, ey, drain);
        repeat (steps) add_cmd(CMD_ADVANCE, $urandom_range(1023), $urandom_range(1023),
                               $urandom_range(1023), $urandom_range(1023));
        added = added + 1 + steps;
      end
      drain = ($urandom_range(99) < 3);
    end
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || expected_pixels.size() > 0 || s_tvalid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    line_x      = '0;
    line_y      = '0;
    line_stop   = '0;
    line_err    = 0;
    line_dmaj   = 0;
    line_dmin   = 0;
    line_mode   = MODE_HORIZ;
    line_active = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle advance after reset
    add_cmd(CMD_ADVANCE, 0, 0, 0, 0);
    // horizontal run, then an idle advance past its end
    add_cmd(CMD_LOAD, 0, 0, 3, 0);
    add_cmd(CMD_ADVANCE, 1023, 1023, 1023, 1023);
    add_cmd(CMD_ADVANCE, 0, 0, 0, 0);
    add_cmd(CMD_ADVANCE, 0, 0, 0, 0);
    // right-to-left horizontal and equal endpoints give empty lines
    add_cmd(CMD_LOAD, 5, 7, 2, 7);
    add_cmd(CMD_LOAD, 1023, 1023, 1023, 1023);
    // single pixel line
    add_cmd(CMD_LOAD, 10, 5, 11, 5);
    add_cmd(CMD_ADVANCE, 0, 0, 0, 0);
    // vertical, top edge of the field
    add_cmd(CMD_LOAD, 1023, 1023, 1023, 1021);
    add_cmd(CMD_ADVANCE, 0, 0, 0, 0);
    // shallow going down from the lower-x end
    add_cmd(CMD_LOAD, 1023, 0, 1021, 1);
    add_cmd(CMD_ADVANCE, 0, 0, 0, 0);
    add_cmd(CMD_ADVANCE, 0, 0, 0, 0);
    // steep going left from the lower-y end
    add_cmd(CMD_LOAD, 0, 1023, 1, 1020);
    repeat (3) add_cmd(CMD_ADVANCE, 0, 0, 0, 0);
    // shallow up, then steep right
    add_cmd(CMD_LOAD, 0, 0, 2, 1);
    repeat (2) add_cmd(CMD_ADVANCE, 0, 0, 0, 0);
    add_cmd(CMD_LOAD, 0, 0, 1, 3);
    repeat (3) add_cmd(CMD_ADVANCE, 0, 0, 0, 0);
    // load abandons a line in progress
    add_cmd(CMD_LOAD, 0, 0, 1023, 1023);
    add_cmd(CMD_ADVANCE, 0, 0, 0, 0);
    add_cmd(CMD_LOAD, 0, 0, 1, 0);
    wait_drained();

    // Random, no idling, with one long receiver hold-off
    add_random(160, 1'b0);
    hold_req = hold_req + 1;
    wait_drained();

    // Sender mostly idle; first command waits for every result
    send_idle_pct = 83;
    add_random(170, 1'b1);
    wait_drained();

    // Receiver mostly stalled
    send_idle_pct  = 0;
    recv_stall_pct = 83;
    add_random(170, 1'b0);
    wait_drained();

    // Light idling on both sides
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    add_random(180, 1'b0);
    wait_drained();

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
